// ===== sv/hsv2rgb_pkg.sv =====
// Shared types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

	localparam int unsigned HueW    = 9;
	localparam int unsigned ChanW   = 8;
	localparam int unsigned SectorW = 4;
	localparam int unsigned RemW    = 6;

	localparam logic [HueW-1:0]  DegPerSector = 9'd60;
	localparam logic [7:0]       FullScale    = 8'd255;
	localparam logic [13:0]      QDenom       = 14'd15300;   // 255 * 60
	localparam logic [SectorW-1:0] SectorCount = 4'd6;
	localparam int unsigned      MaxSector    = 8;           // 511 / 60

	// Reciprocal of 15300 scaled by 2^36, rounded up; exact for numerators below 2^22.
	localparam int unsigned      QRecipShift  = 36;
	localparam logic [22:0]      QRecip       = 23'd4491470;

	// Sector codes of the six-sector mux.
	localparam logic [SectorW-1:0] SecRed     = 4'd0;
	localparam logic [SectorW-1:0] SecYellow  = 4'd1;
	localparam logic [SectorW-1:0] SecGreen   = 4'd2;
	localparam logic [SectorW-1:0] SecCyan    = 4'd3;
	localparam logic [SectorW-1:0] SecBlue    = 4'd4;
	localparam logic [SectorW-1:0] SecMagenta = 4'd5;

	// Hue split into sector and remainder.
	typedef struct packed {
		logic               valid;
		logic [SectorW-1:0] sector;
		logic [RemW-1:0]    rem;
		logic [ChanW-1:0]   sat;
		logic [ChanW-1:0]   val;
	} split_t;

	// Finished p, q, t terms with the value and sector.
	typedef struct packed {
		logic               valid;
		logic [SectorW-1:0] sector;
		logic [ChanW-1:0]   val;
		logic [ChanW-1:0]   p;
		logic [ChanW-1:0]   q;
		logic [ChanW-1:0]   t;
	} terms_t;

endpackage

// ===== sv/hsv2rgb_if.sv =====
// Valid/ready stream interfaces for the pixel request and the color result.
interface hsv2rgb_pixel_if;
	logic       valid;
	logic       ready;
	logic [8:0] hue_deg;
	logic [7:0] saturation;
	logic [7:0] brightness;

	modport source (output valid, output hue_deg, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue_deg, input saturation, input brightness,
		output ready);
endinterface

interface hsv2rgb_color_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/hsv2rgb_split.sv =====
// Stage 1: split the hue into sector and remainder within the sector.
module hsv2rgb_split (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid,
	input  logic [hsv2rgb_pkg::HueW-1:0]      hue_deg,
	input  logic [hsv2rgb_pkg::ChanW-1:0]     saturation,
	input  logic [hsv2rgb_pkg::ChanW-1:0]     brightness,
	output hsv2rgb_pkg::split_t               split_s1
);

	logic [hsv2rgb_pkg::SectorW-1:0] sector;
	logic [hsv2rgb_pkg::HueW-1:0]    base;
	logic [hsv2rgb_pkg::HueW-1:0]    rem_full;

	logic                            valid_s1;
	logic [hsv2rgb_pkg::SectorW-1:0] sector_s1;
	logic [hsv2rgb_pkg::RemW-1:0]    rem_s1;
	logic [hsv2rgb_pkg::ChanW-1:0]   sat_s1;
	logic [hsv2rgb_pkg::ChanW-1:0]   val_s1;

	// Independent threshold compares; the highest one passed names the sector.
	always_comb begin
		sector = '0;
		base   = '0;
		for (int k = 1; k <= hsv2rgb_pkg::MaxSector; k++) begin
			if (hue_deg >= hsv2rgb_pkg::HueW'(k * 60)) begin
				sector = hsv2rgb_pkg::SectorW'(k);
				base   = hsv2rgb_pkg::HueW'(k * 60);
			end
		end
		rem_full = hue_deg - base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s1 <= sector;
			rem_s1    <= rem_full[hsv2rgb_pkg::RemW-1:0];
			sat_s1    <= saturation;
			val_s1    <= brightness;
		end
	end

	assign split_s1 = '{valid: valid_s1, sector: sector_s1, rem: rem_s1, sat: sat_s1,
		val: val_s1};

endmodule

// ===== sv/hsv2rgb_terms.sv =====
// Stages 2 to 4: form the p, q and t terms with exact truncation.
module hsv2rgb_terms (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  hsv2rgb_pkg::split_t  split_s1,
	output hsv2rgb_pkg::terms_t  terms_s4
);

	// Stage 2: products of saturation.
	logic                            valid_s2;
	logic [hsv2rgb_pkg::SectorW-1:0] sector_s2;
	logic [7:0]                      val_s2;
	logic [15:0]                     pnum_s2;
	logic [13:0]                     sr_s2;
	logic [13:0]                     st_s2;

	// Stage 3: p finished, q and t numerators.
	logic                            valid_s3;
	logic [hsv2rgb_pkg::SectorW-1:0] sector_s3;
	logic [7:0]                      val_s3;
	logic [7:0]                      p_s3;
	logic [21:0]                     qnum_s3;
	logic [21:0]                     tnum_s3;

	// Stage 4: finished terms.
	logic                            valid_s4;
	logic [hsv2rgb_pkg::SectorW-1:0] sector_s4;
	logic [7:0]                      val_s4;
	logic [7:0]                      p_s4;
	logic [7:0]                      q_s4;
	logic [7:0]                      t_s4;

	logic [6:0]  rem_c;
	logic [16:0] psum;
	logic [13:0] qdiff;
	logic [13:0] tdiff;
	logic [44:0] qprod;
	logic [44:0] tprod;

	always_comb begin
		rem_c = 7'd60 - 7'(split_s1.rem);
		// x / 255 for x below 65535: (x + (x >> 8) + 1) >> 8.
		psum  = 17'(pnum_s2) + 17'(pnum_s2[15:8]) + 17'd1;
		qdiff = hsv2rgb_pkg::QDenom - sr_s2;
		tdiff = hsv2rgb_pkg::QDenom - st_s2;
		qprod = 45'(qnum_s3) * 45'(hsv2rgb_pkg::QRecip);
		tprod = 45'(tnum_s3) * 45'(hsv2rgb_pkg::QRecip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= split_s1.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s2 <= split_s1.sector;
			val_s2    <= split_s1.val;
			pnum_s2   <= 16'(split_s1.val) * 16'(hsv2rgb_pkg::FullScale - split_s1.sat);
			sr_s2     <= 14'(split_s1.sat) * 14'(split_s1.rem);
			st_s2     <= 14'(split_s1.sat) * 14'(rem_c);

			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			p_s3      <= psum[15:8];
			qnum_s3   <= 22'(val_s2) * 22'(qdiff);
			tnum_s3   <= 22'(val_s2) * 22'(tdiff);

			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
			p_s4      <= p_s3;
			q_s4      <= qprod[hsv2rgb_pkg::QRecipShift+7:hsv2rgb_pkg::QRecipShift];
			t_s4      <= tprod[hsv2rgb_pkg::QRecipShift+7:hsv2rgb_pkg::QRecipShift];
		end
	end

	assign terms_s4 = '{valid: valid_s4, sector: sector_s4, val: val_s4, p: p_s4, q: q_s4,
		t: t_s4};

endmodule

// ===== sv/hsv_to_rgb_converter_top.sv =====
// Top level of the HSV to RGB converter: pipeline control and sector mux.
//
//   Channel   Role    Payload                              Meaning
//   pixel     sink    hue_deg[9], saturation[8],           one pixel request in HSV
//                     brightness[8]
//   color     source  red[8], green[8], blue[8]            the converted RGB pixel
//
// One pixel per clock sustained unless color stalls; a request passes the split,
// products, p and numerators and reciprocal multiply registers and the sector mux
// into the output register. The reciprocal multiply (22 x 23 bits) sets the clock.
// arst_n clears every valid bit; payload registers are not reset.
// A stall on color freezes all stages together, so nothing is dropped or repeated;
// pixel.ready follows color.ready whenever the output register is full.
module hsv_to_rgb_converter_top (
	input  logic            clk,
	input  logic            arst_n,
	hsv2rgb_pixel_if.sink   pixel,
	hsv2rgb_color_if.source color
);

	logic                 en;
	hsv2rgb_pkg::split_t  split_s1;
	hsv2rgb_pkg::terms_t  terms_s4;
	logic                 valid_q;
	logic [7:0]           red_q;
	logic [7:0]           green_q;
	logic [7:0]           blue_q;
	logic [7:0]           red_c;
	logic [7:0]           green_c;
	logic [7:0]           blue_c;

	// Advance the whole pipe unless a finished pixel waits at the output.
	assign en          = !valid_q || color.ready;
	assign pixel.ready = en;

	hsv2rgb_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (pixel.valid),
		.hue_deg    (pixel.hue_deg),
		.saturation (pixel.saturation),
		.brightness (pixel.brightness),
		.split_s1   (split_s1)
	);

	hsv2rgb_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.split_s1 (split_s1),
		.terms_s4 (terms_s4)
	);

	// Six-sector mux; sectors six and above (hue 360 and beyond) map as red.
	always_comb begin
		case (terms_s4.sector)
			hsv2rgb_pkg::SecYellow: begin
				red_c = terms_s4.q;   green_c = terms_s4.val; blue_c = terms_s4.p;
			end
			hsv2rgb_pkg::SecGreen: begin
				red_c = terms_s4.p;   green_c = terms_s4.val; blue_c = terms_s4.t;
			end
			hsv2rgb_pkg::SecCyan: begin
				red_c = terms_s4.p;   green_c = terms_s4.q;   blue_c = terms_s4.val;
			end
			hsv2rgb_pkg::SecBlue: begin
				red_c = terms_s4.t;   green_c = terms_s4.p;   blue_c = terms_s4.val;
			end
			hsv2rgb_pkg::SecMagenta: begin
				red_c = terms_s4.val; green_c = terms_s4.p;   blue_c = terms_s4.q;
			end
			default: begin
				red_c = terms_s4.val; green_c = terms_s4.t;   blue_c = terms_s4.p;
			end
		endcase
	end

	// Output register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= terms_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_q   <= red_c;
			green_q <= green_c;
			blue_q  <= blue_c;
		end
	end

	assign color.valid = valid_q;
	assign color.red   = red_q;
	assign color.green = green_q;
	assign color.blue  = blue_q;

endmodule

// ===== sv/hsv2rgb_checker.sv =====
// Port-level checker for the HSV to RGB converter and its bind.
module hsv2rgb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_valid,
	input logic       pixel_ready,
	input logic       color_valid,
	input logic       color_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// A request is taken whenever the output is free or being drained.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!color_valid || color_ready) |-> pixel_ready)
		else $error("pixel not accepted while pipe can advance");

	// While color_ready stays high, a taken request comes out as color_valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_ready) ##1 color_ready ##1 color_ready ##1 color_ready
		##1 color_ready |=> color_valid)
		else $error("result missing after pipeline latency");

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(color_valid && !color_ready) |=>
		(color_valid && $stable(red) && $stable(green) && $stable(blue)))
		else $error("stalled result changed");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel.valid),
	.pixel_ready (pixel.ready),
	.color_valid (color.valid),
	.color_ready (color.ready),
	.red         (color.red),
	.green       (color.green),
	.blue        (color.blue)
);
